// ----- src/nfse_pkg.sv -----
// Package for the sentence speed field extractor.
// Holds character codes, the value limit and the result type; no dependencies.
package nfse_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;
    localparam int VALUE_W = 27;
    localparam int SUM_W   = 31;
    localparam int FRAC_W  = 2;

    localparam logic [BYTE_W-1:0]  NL_BYTE    = 8'h0A;
    localparam logic [BYTE_W-1:0]  COMMA_BYTE = 8'h2C;
    localparam logic [BYTE_W-1:0]  POINT_BYTE = 8'h2E;
    localparam logic [BYTE_W-1:0]  ZERO_BYTE  = 8'h30;
    localparam logic [BYTE_W-1:0]  NINE_BYTE  = 8'h39;

    localparam logic [VALUE_W-1:0] VALUE_MAX          = 27'd99999999;
    localparam logic [COUNT_W-1:0] FIELD_COMMAS_RESET = 5'd7;
    localparam logic [FRAC_W-1:0]  FRAC_DIGITS_MAX    = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] speed_milli;
        logic               field_found;
        logic               saturated;
    } speed_result_t;

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] rx_byte;
    } byte_slot_t;

endpackage

// ----- src/nfse_byte_if.sv -----
// Input channel carrying one received character per item.
// Depends on nfse_pkg for the byte width.
interface nfse_byte_if;
    logic                        valid;
    logic                        ready;
    logic [nfse_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/nfse_speed_if.sv -----
// Output channel carrying one extracted speed result per item.
// Depends on nfse_pkg for the value width.
interface nfse_speed_if;
    logic                         valid;
    logic                         ready;
    logic [nfse_pkg::VALUE_W-1:0] speed_milli;
    logic                         field_found;
    logic                         saturated;

    modport source (output valid, output speed_milli, output field_found,
                    output saturated, input ready);
    modport sink   (input valid, input speed_milli, input field_found,
                    input saturated, output ready);
endinterface

// ----- src/nfse_in_stage.sv -----
// Input register: holds one received character until the converter takes it.
// Depends on nfse_pkg.
module nfse_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [nfse_pkg::BYTE_W-1:0] in_byte,
    output logic                        in_ready,
    input  logic                        take,
    output nfse_pkg::byte_slot_t        slot
);

    logic                        vld_reg;
    logic                        vld_next;
    logic [nfse_pkg::BYTE_W-1:0] byte_reg;

    assign in_ready = !vld_reg || take;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign slot.vld     = vld_reg;
    assign slot.rx_byte = byte_reg;

endmodule

// ----- src/nfse_field_conv.sv -----
// Line state and decimal-to-thousandths conversion, one character per cycle; newlines wait for a free result slot.
// Holds the field_commas register. Depends on nfse_pkg.
module nfse_field_conv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [nfse_pkg::COUNT_W-1:0] cfg_data,
    input  nfse_pkg::byte_slot_t         slot,
    input  logic                         out_free,
    output logic                         take,
    output logic                         push,
    output nfse_pkg::speed_result_t      result
);

    logic [nfse_pkg::COUNT_W-1:0] field_commas_reg;
    logic [nfse_pkg::COUNT_W-1:0] comma_count_reg;
    logic [nfse_pkg::COUNT_W-1:0] comma_count_next;
    logic [nfse_pkg::VALUE_W-1:0] value_accum_reg;
    logic [nfse_pkg::VALUE_W-1:0] value_accum_next;
    logic                         in_fraction_reg;
    logic                         in_fraction_next;
    logic [nfse_pkg::FRAC_W-1:0]  fraction_digits_reg;
    logic [nfse_pkg::FRAC_W-1:0]  fraction_digits_next;
    logic                         number_ended_reg;
    logic                         number_ended_next;
    logic                         overflow_seen_reg;
    logic                         overflow_seen_next;

    logic                         is_nl;
    logic                         is_digit;
    logic                         reached;
    logic [3:0]                   digit;
    logic [nfse_pkg::SUM_W-1:0]   acc_ext;
    logic [nfse_pkg::SUM_W-1:0]   int_sum;
    logic [nfse_pkg::SUM_W-1:0]   frac_sum;
    logic [nfse_pkg::SUM_W-1:0]   sum;
    logic [6:0]                   frac_weight;

    assign is_nl    = (slot.rx_byte == nfse_pkg::NL_BYTE);
    assign is_digit = (slot.rx_byte >= nfse_pkg::ZERO_BYTE) &&
                      (slot.rx_byte <= nfse_pkg::NINE_BYTE);
    assign digit    = slot.rx_byte[3:0];
    assign reached  = (comma_count_reg >= field_commas_reg);

    assign take = slot.vld && (!is_nl || out_free);
    assign push = take && is_nl;

    assign result.speed_milli = reached ? value_accum_reg : '0;
    assign result.field_found = reached;
    assign result.saturated   = reached && overflow_seen_reg;

    always_comb
    begin
        case (fraction_digits_reg)
            2'd0:    frac_weight = 7'd100;
            2'd1:    frac_weight = 7'd10;
            default: frac_weight = 7'd1;
        endcase
    end

    assign acc_ext  = {{(nfse_pkg::SUM_W-nfse_pkg::VALUE_W){1'b0}}, value_accum_reg};
    assign int_sum  = (acc_ext << 3) + (acc_ext << 1) +
                      nfse_pkg::SUM_W'(digit) * nfse_pkg::SUM_W'(1000);
    assign frac_sum = acc_ext + nfse_pkg::SUM_W'(digit) * nfse_pkg::SUM_W'(frac_weight);
    assign sum      = in_fraction_reg ? frac_sum : int_sum;

    always_comb
    begin
        comma_count_next     = comma_count_reg;
        value_accum_next     = value_accum_reg;
        in_fraction_next     = in_fraction_reg;
        fraction_digits_next = fraction_digits_reg;
        number_ended_next    = number_ended_reg;
        overflow_seen_next   = overflow_seen_reg;
        if (take)
        begin
            if (is_nl)
            begin
                comma_count_next     = '0;
                value_accum_next     = '0;
                in_fraction_next     = 1'b0;
                fraction_digits_next = '0;
                number_ended_next    = 1'b0;
                overflow_seen_next   = 1'b0;
            end
            else if (!reached)
            begin
                if (slot.rx_byte == nfse_pkg::COMMA_BYTE)
                begin
                    comma_count_next = comma_count_reg + 1'b1;
                end
            end
            else if (slot.rx_byte == nfse_pkg::COMMA_BYTE)
            begin
                number_ended_next = 1'b1;
            end
            else if (!number_ended_reg)
            begin
                if (is_digit)
                begin
                    if (!in_fraction_reg ||
                        fraction_digits_reg != nfse_pkg::FRAC_DIGITS_MAX)
                    begin
                        if (sum > nfse_pkg::SUM_W'(nfse_pkg::VALUE_MAX))
                        begin
                            value_accum_next   = nfse_pkg::VALUE_MAX;
                            overflow_seen_next = 1'b1;
                        end
                        else
                        begin
                            value_accum_next = sum[nfse_pkg::VALUE_W-1:0];
                        end
                        if (in_fraction_reg)
                        begin
                            fraction_digits_next = fraction_digits_reg + 1'b1;
                        end
                    end
                end
                else if (slot.rx_byte == nfse_pkg::POINT_BYTE && !in_fraction_reg)
                begin
                    in_fraction_next = 1'b1;
                end
                else
                begin
                    number_ended_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_commas_reg    <= nfse_pkg::FIELD_COMMAS_RESET;
            comma_count_reg     <= '0;
            value_accum_reg     <= '0;
            in_fraction_reg     <= 1'b0;
            fraction_digits_reg <= '0;
            number_ended_reg    <= 1'b0;
            overflow_seen_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                field_commas_reg <= cfg_data;
            end
            comma_count_reg     <= comma_count_next;
            value_accum_reg     <= value_accum_next;
            in_fraction_reg     <= in_fraction_next;
            fraction_digits_reg <= fraction_digits_next;
            number_ended_reg    <= number_ended_next;
            overflow_seen_reg   <= overflow_seen_next;
        end
    end

endmodule

// ----- src/nfse_out_stage.sv -----
// Result register: holds one finished result until the receiver takes it.
// Depends on nfse_pkg.
module nfse_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  nfse_pkg::speed_result_t result,
    output logic                    out_free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output nfse_pkg::speed_result_t out_data
);

    logic                    vld_reg;
    logic                    vld_next;
    nfse_pkg::speed_result_t data_reg;

    assign out_free  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (out_ready)
        begin
            vld_next = 1'b0;
        end
        if (push)
        begin
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= result;
        end
    end

endmodule

// ----- src/nmea_field_speed_extractor_top.sv -----
// Top level of the sentence speed field extractor.
// Depends on nfse_pkg, nfse_byte_if, nfse_speed_if, nfse_in_stage,
// nfse_field_conv and nfse_out_stage.
//
// Usage:
//   in_ch  takes one received character per item (valid/ready).
//   out_ch gives one result per newline: speed_milli in thousandths,
//          field_found and saturated. Other characters give no item.
//   cfg_we/cfg_data write field_commas, the comma count before the field;
//   write it only while no line is in progress.
// Timing:
//   One character per cycle while no newline waits on a held result. A
//   character is held in the input register and then folded into the line
//   state; a newline's result is loaded into the result register at the
//   same edge that clears the line state, and is valid from then on.
//   The per-character update of the line state is the register feedback loop.
// Reset: clears the line state, empties both registers, field_commas = 7.
// Stall: a held result blocks only the next newline; other characters keep
//   flowing until that newline reaches the converter, then in_ch.ready drops.
module nmea_field_speed_extractor_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [nfse_pkg::COUNT_W-1:0] cfg_data,
    nfse_byte_if.sink                    in_ch,
    nfse_speed_if.source                 out_ch
);

    nfse_pkg::byte_slot_t    slot;
    nfse_pkg::speed_result_t result;
    nfse_pkg::speed_result_t out_data;
    logic                    take;
    logic                    push;
    logic                    out_free;

    nfse_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_byte  (in_ch.rx_byte),
        .in_ready (in_ch.ready),
        .take     (take),
        .slot     (slot)
    );

    nfse_field_conv u_field_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .slot     (slot),
        .out_free (out_free),
        .take     (take),
        .push     (push),
        .result   (result)
    );

    nfse_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.speed_milli = out_data.speed_milli;
    assign out_ch.field_found = out_data.field_found;
    assign out_ch.saturated   = out_data.saturated;

endmodule

// ----- verif/nmea_field_speed_extractor_top_test.sv -----
// Testbench for nmea_field_speed_extractor_top: drives received characters, predicts
// each newline result and checks it field by field, with random idling on both channels.
// Depends on nfse_pkg, nfse_byte_if, nfse_speed_if and the block's RTL.
module nmea_field_speed_extractor_top_test;

    localparam logic [nfse_pkg::BYTE_W-1:0] CR_BYTE     = 8'h0D;
    localparam logic [nfse_pkg::BYTE_W-1:0] NUL_BYTE    = 8'h00;
    localparam logic [nfse_pkg::BYTE_W-1:0] HIGH_BYTE   = 8'hFF;
    localparam int                          CYCLE_LIMIT = 400000;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [nfse_pkg::COUNT_W-1:0] cfg_data;

    nfse_byte_if  in_ch ();
    nfse_speed_if out_ch ();

    nmea_field_speed_extractor_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // predicted line state
    logic [nfse_pkg::COUNT_W-1:0] field_commas_cfg;
    logic [nfse_pkg::COUNT_W-1:0] line_commas;
    logic [nfse_pkg::VALUE_W-1:0] speed_accum;
    logic                         past_point;
    logic [nfse_pkg::FRAC_W-1:0]  point_digits;
    logic                         field_closed;
    logic                         clamp_seen;

    nfse_pkg::speed_result_t pending_speeds[$];

    int mismatch_count = 0;
    int sent_items     = 0;
    int cycle_count    = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void clear_line_state();
        line_commas  = '0;
        speed_accum  = '0;
        past_point   = 1'b0;
        point_digits = '0;
        field_closed = 1'b0;
        clamp_seen   = 1'b0;
    endfunction

    function automatic void add_with_clamp(input longint unsigned sum);
        if (sum > nfse_pkg::VALUE_MAX)
        begin
            speed_accum = nfse_pkg::VALUE_MAX;
            clamp_seen  = 1'b1;
        end
        else
            speed_accum = nfse_pkg::VALUE_W'(sum);
    endfunction

    function automatic void advance_speed_parser(input logic [nfse_pkg::BYTE_W-1:0] b);
        nfse_pkg::speed_result_t res;
        logic                    reached;
        longint unsigned         digit;
        longint unsigned         weight;
        reached = (line_commas >= field_commas_cfg);
        if (b == nfse_pkg::NL_BYTE)
        begin
            res.speed_milli = reached ? speed_accum : '0;
            res.field_found = reached;
            res.saturated   = reached ? clamp_seen : 1'b0;
            pending_speeds.push_back(res);
            clear_line_state();
        end
        else if (!reached)
        begin
            if (b == nfse_pkg::COMMA_BYTE)
                line_commas = line_commas + 1'b1;
        end
        else if (b == nfse_pkg::COMMA_BYTE)
            field_closed = 1'b1;
        else if (!field_closed)
        begin
            if (b >= nfse_pkg::ZERO_BYTE && b <= nfse_pkg::NINE_BYTE)
            begin
                digit = longint'(b - nfse_pkg::ZERO_BYTE);
                if (!past_point)
                    add_with_clamp(longint'(speed_accum) * 10 + digit * 1000);
                else if (point_digits < nfse_pkg::FRAC_DIGITS_MAX)
                begin
                    case (point_digits)
                        2'd0:    weight = 100;
                        2'd1:    weight = 10;
                        default: weight = 1;
                    endcase
                    add_with_clamp(longint'(speed_accum) + digit * weight);
                    point_digits = point_digits + 1'b1;
                end
            end
            else if (b == nfse_pkg::POINT_BYTE && !past_point)
                past_point = 1'b1;
            else
                field_closed = 1'b1;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        nfse_pkg::speed_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_speeds.size() == 0)
            begin
                $display("%0t: unexpected result speed_milli %0d field_found %0b saturated %0b",
                         $time, out_ch.speed_milli, out_ch.field_found, out_ch.saturated);
                mismatch_count++;
            end
            else
            begin
                want = pending_speeds.pop_front();
                if (out_ch.speed_milli !== want.speed_milli)
                begin
                    $display("%0t: speed_milli expected %0d actual %0d",
                             $time, want.speed_milli, out_ch.speed_milli);
                    mismatch_count++;
                end
                if (out_ch.field_found !== want.field_found)
                begin
                    $display("%0t: field_found expected %0b actual %0b",
                             $time, want.field_found, out_ch.field_found);
                    mismatch_count++;
                end
                if (out_ch.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.saturated, out_ch.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [nfse_pkg::BYTE_W-1:0] b);
        int gap;
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        advance_speed_parser(b);
        sent_items++;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid   <= 1'b0;
            in_ch.rx_byte <= nfse_pkg::BYTE_W'($urandom);
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(nfse_pkg::BYTE_W'(s[i]));
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_field_commas(input logic [nfse_pkg::COUNT_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        field_commas_cfg = v;
    endtask

    function automatic logic [nfse_pkg::BYTE_W-1:0] rand_digit();
        return nfse_pkg::ZERO_BYTE + nfse_pkg::BYTE_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [nfse_pkg::BYTE_W-1:0] rand_text_byte();
        logic [nfse_pkg::BYTE_W-1:0] b;
        b = nfse_pkg::BYTE_W'($urandom_range(0, 255));
        while (b == nfse_pkg::NL_BYTE || b == nfse_pkg::COMMA_BYTE)
            b = nfse_pkg::BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [nfse_pkg::COUNT_W-1:0] pick_field_commas();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return nfse_pkg::COUNT_W'($urandom_range(0, 8));
        else if (r == 6)
            return '0;
        else if (r == 7)
            return '1;
        return nfse_pkg::COUNT_W'($urandom_range(0, 31));
    endfunction

    // mostly well-formed lines with random content, the rest raw noise
    task automatic send_random_line();
        logic [nfse_pkg::BYTE_W-1:0] line_q[$];
        int lead;
        int n_int;
        if ($urandom_range(0, 99) < 80)
        begin
            lead = ($urandom_range(0, 99) < 75) ? int'(field_commas_cfg)
                                                : $urandom_range(0, field_commas_cfg + 2);
            for (int i = 0; i < lead; i++)
            begin
                repeat ($urandom_range(0, 2))
                    line_q.push_back(rand_text_byte());
                line_q.push_back(nfse_pkg::COMMA_BYTE);
            end
            n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 5);
            repeat (n_int)
                line_q.push_back(rand_digit());
            if ($urandom_range(0, 99) < 60)
            begin
                line_q.push_back(nfse_pkg::POINT_BYTE);
                repeat ($urandom_range(0, 5))
                    line_q.push_back(rand_digit());
            end
            case ($urandom_range(0, 5))
                0:       line_q.push_back(nfse_pkg::COMMA_BYTE);
                1:       line_q.push_back(CR_BYTE);
                2:       line_q.push_back(nfse_pkg::POINT_BYTE);
                3:       line_q.push_back(rand_text_byte());
                default: ;
            endcase
            repeat ($urandom_range(0, 4))
                line_q.push_back(($urandom_range(0, 3) == 0) ? nfse_pkg::COMMA_BYTE
                                                             : rand_text_byte());
            line_q.push_back(nfse_pkg::NL_BYTE);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                line_q.push_back(nfse_pkg::BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) != 0)
                line_q.push_back(nfse_pkg::NL_BYTE);
        end
        foreach (line_q[i])
            send_byte(line_q[i]);
    endtask

    task automatic test_default_field();
        send_text(",,\n");
        send_text(",,,,,,,9.5\n");
        pause_until_drained();
    endtask

    task automatic test_number_forms();
        write_field_commas('0);
        send_text("\n");
        send_text("99999.999\n");
        send_text("100000\n");
        send_text("1.2345\n");
        send_text("2.5.7\n");
        send_text(",3\n");
        send_text("12\r\n");
        send_text("-4\n");
        send_byte(rand_digit());
        send_byte(NUL_BYTE);
        send_text("9\n");
        send_byte(rand_digit());
        send_byte(HIGH_BYTE);
        send_text(".75\n");
        pause_until_drained();
    endtask

    task automatic test_wide_field();
        write_field_commas('1);
        for (int i = 0; i < 31; i++)
        begin
            send_byte(rand_text_byte());
            send_byte(nfse_pkg::COMMA_BYTE);
        end
        send_text("123.4,5,,,,,,\n");
        repeat (30)
            send_byte(nfse_pkg::COMMA_BYTE);
        send_byte(nfse_pkg::NL_BYTE);
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_stall, input int n_items);
        int first_item;
        int lines;
        sender_idle_pct = send_idle;
        recv_stall_pct  = recv_stall;
        first_item = sent_items;
        lines = 0;
        write_field_commas(pick_field_commas());
        while (sent_items - first_item < n_items)
        begin
            send_random_line();
            lines++;
            if (lines % 12 == 0)
            begin
                send_byte(nfse_pkg::NL_BYTE);
                pause_until_drained();
                write_field_commas(pick_field_commas());
            end
        end
        send_byte(nfse_pkg::NL_BYTE);
        pause_until_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        field_commas_cfg = nfse_pkg::FIELD_COMMAS_RESET;
        clear_line_state();
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;

        test_default_field();
        test_number_forms();
        test_wide_field();
        test_random_traffic(0, 0, 445);
        test_random_traffic(48, 0, 445);
        test_random_traffic(0, 48, 445);
        test_random_traffic(23, 23, 445);

        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0 && pending_speeds.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
